/* rtl/lru_pkg.sv */
// ----------------------------------------------------------------------------
// lru_pkg
// Shared widths, sequencer states, memory control bundle and page reduction
// for the lru page replacement core.
// ----------------------------------------------------------------------------
package lru_pkg;

  localparam int unsigned PAGE_W         = 8;
  localparam int unsigned FRAME_W        = 2;
  localparam int unsigned DEF_NUM_FRAMES = 4;
  localparam int unsigned MAX_PAGES      = 256;
  localparam int unsigned PAGE_MOD       = (MAX_PAGES < (2 ** PAGE_W)) ? MAX_PAGES
                                                                       : (2 ** PAGE_W);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_AGE,
    S_RESULT
  } lru_state_t;

  typedef struct packed {
    logic rd_en;
    logic page_we;
    logic rank_we;
    logic set_valid;
  } lru_mem_ctl_t;

  // page number modulo the page space, a power of two
  function automatic logic [PAGE_W-1:0] lru_page_reduce(input logic [PAGE_W-1:0] p);
    return p & PAGE_W'(PAGE_MOD - 1);
  endfunction

endpackage

/* rtl/lru_if.sv */
// ----------------------------------------------------------------------------
// lru channel interfaces
// Valid/ready channels for page accesses and replacement results.
// ----------------------------------------------------------------------------
interface lru_req_if;
  logic                        valid;
  logic                        ready;
  logic [lru_pkg::PAGE_W-1:0]  page_id;

  modport source (output valid, output page_id, input ready);
  modport sink   (input valid, input page_id, output ready);
endinterface

interface lru_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        hit;
  logic [lru_pkg::FRAME_W-1:0] frame;
  logic                        evicted_valid;
  logic [lru_pkg::PAGE_W-1:0]  evicted_page;

  modport source (output valid, output hit, output frame, output evicted_valid,
                  output evicted_page, input ready);
  modport sink   (input valid, input hit, input frame, input evicted_valid,
                  input evicted_page, output ready);
endinterface

/* rtl/lru_frame_store.sv */
// ----------------------------------------------------------------------------
// lru_frame_store
// Frame page and rank memories with registered read, plus frame valid flags.
// ----------------------------------------------------------------------------
module lru_frame_store #(
  parameter int unsigned NUM_FRAMES = lru_pkg::DEF_NUM_FRAMES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lru_pkg::lru_mem_ctl_t         ctl,
  input  logic [$clog2(NUM_FRAMES)-1:0] rd_addr,
  input  logic [$clog2(NUM_FRAMES)-1:0] wr_addr,
  input  logic [lru_pkg::PAGE_W-1:0]    wr_page,
  input  logic [$clog2(NUM_FRAMES)-1:0] wr_rank,
  output logic [lru_pkg::PAGE_W-1:0]    rd_page,
  output logic [$clog2(NUM_FRAMES)-1:0] rd_rank,
  output logic [NUM_FRAMES-1:0]         valid
);

  localparam int unsigned IW = $clog2(NUM_FRAMES);

  logic [lru_pkg::PAGE_W-1:0] page_mem [NUM_FRAMES];
  logic [IW-1:0]              rank_mem [NUM_FRAMES];

  logic [lru_pkg::PAGE_W-1:0] rd_page_r;
  logic [IW-1:0]              rd_rank_r;
  logic [NUM_FRAMES-1:0]      valid_r;

  always_ff @(posedge clk) begin
    if (ctl.page_we) begin
      page_mem[wr_addr] <= wr_page;
    end
    if (ctl.rank_we) begin
      rank_mem[wr_addr] <= wr_rank;
    end
    if (ctl.rd_en) begin
      rd_page_r <= page_mem[rd_addr];
      rd_rank_r <= rank_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (ctl.set_valid) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  assign rd_page = rd_page_r;
  assign rd_rank = rd_rank_r;
  assign valid   = valid_r;

endmodule

/* rtl/lru_ctrl.sv */
// ----------------------------------------------------------------------------
// lru_ctrl
// Access sequencer: a lookup pass over the frames, then a rank update pass,
// then the result register.
// ----------------------------------------------------------------------------
module lru_ctrl #(
  parameter int unsigned NUM_FRAMES = lru_pkg::DEF_NUM_FRAMES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lru_pkg::PAGE_W-1:0]    in_page_id,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_hit,
  output logic [lru_pkg::FRAME_W-1:0]   out_frame,
  output logic                          out_evicted_valid,
  output logic [lru_pkg::PAGE_W-1:0]    out_evicted_page,
  output lru_pkg::lru_mem_ctl_t         mem_ctl,
  output logic [$clog2(NUM_FRAMES)-1:0] mem_rd_addr,
  output logic [$clog2(NUM_FRAMES)-1:0] mem_wr_addr,
  output logic [lru_pkg::PAGE_W-1:0]    mem_wr_page,
  output logic [$clog2(NUM_FRAMES)-1:0] mem_wr_rank,
  input  logic [lru_pkg::PAGE_W-1:0]    mem_rd_page,
  input  logic [$clog2(NUM_FRAMES)-1:0] mem_rd_rank,
  input  logic [NUM_FRAMES-1:0]         frame_valid
);

  localparam int unsigned IW = $clog2(NUM_FRAMES);
  localparam int unsigned CW = $clog2(NUM_FRAMES + 1);

  lru_pkg::lru_state_t state_r, state_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;

  logic [lru_pkg::PAGE_W-1:0]  key_r, key_nxt;
  logic                        hit_found_r, hit_found_nxt;
  logic [IW-1:0]               hit_idx_r, hit_idx_nxt;
  logic [IW-1:0]               hit_rank_r, hit_rank_nxt;
  logic                        empty_found_r, empty_found_nxt;
  logic [IW-1:0]               empty_idx_r, empty_idx_nxt;
  logic [IW-1:0]               vic_idx_r, vic_idx_nxt;
  logic [IW-1:0]               vic_rank_r, vic_rank_nxt;
  logic [lru_pkg::PAGE_W-1:0]  vic_page_r, vic_page_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic                        out_hit_r, out_hit_nxt;
  logic [lru_pkg::FRAME_W-1:0] out_frame_r, out_frame_nxt;
  logic                        out_ev_valid_r, out_ev_valid_nxt;
  logic [lru_pkg::PAGE_W-1:0]  out_ev_page_r, out_ev_page_nxt;

  logic          last;
  logic [IW-1:0] chk_idx;
  logic          chk_valid;
  logic          use_empty;
  logic          evict;
  logic [IW-1:0] slot;

  assign last      = (cnt_r == CW'(NUM_FRAMES));
  assign chk_idx   = IW'(cnt_r - CW'(1));
  assign chk_valid = frame_valid[chk_idx];
  assign use_empty = !hit_found_r && empty_found_r;
  assign evict     = !hit_found_r && !empty_found_r;
  assign slot      = hit_found_r ? hit_idx_r : (use_empty ? empty_idx_r : vic_idx_r);

  always_comb begin
    state_nxt        = state_r;
    cnt_nxt          = cnt_r;
    key_nxt          = key_r;
    hit_found_nxt    = hit_found_r;
    hit_idx_nxt      = hit_idx_r;
    hit_rank_nxt     = hit_rank_r;
    empty_found_nxt  = empty_found_r;
    empty_idx_nxt    = empty_idx_r;
    vic_idx_nxt      = vic_idx_r;
    vic_rank_nxt     = vic_rank_r;
    vic_page_nxt     = vic_page_r;
    out_valid_nxt    = out_valid_r;
    out_hit_nxt      = out_hit_r;
    out_frame_nxt    = out_frame_r;
    out_ev_valid_nxt = out_ev_valid_r;
    out_ev_page_nxt  = out_ev_page_r;
    mem_ctl          = '0;
    mem_rd_addr      = IW'(cnt_r);
    mem_wr_addr      = chk_idx;
    mem_wr_page      = key_r;
    mem_wr_rank      = '0;
    in_ready         = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      lru_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          key_nxt         = lru_pkg::lru_page_reduce(in_page_id);
          cnt_nxt         = '0;
          hit_found_nxt   = 1'b0;
          empty_found_nxt = 1'b0;
          state_nxt       = lru_pkg::S_SCAN;
        end
      end

      lru_pkg::S_SCAN: begin
        mem_ctl.rd_en = !last;
        if (cnt_r != '0) begin
          if (chk_valid && (mem_rd_page == key_r) && !hit_found_r) begin
            hit_found_nxt = 1'b1;
            hit_idx_nxt   = chk_idx;
            hit_rank_nxt  = mem_rd_rank;
          end
          if (!chk_valid && !empty_found_r) begin
            empty_found_nxt = 1'b1;
            empty_idx_nxt   = chk_idx;
          end
          if ((cnt_r == CW'(1)) || (mem_rd_rank > vic_rank_r)) begin
            vic_idx_nxt  = chk_idx;
            vic_rank_nxt = mem_rd_rank;
            vic_page_nxt = mem_rd_page;
          end
        end
        cnt_nxt = cnt_r + CW'(1);
        if (last) begin
          cnt_nxt   = '0;
          state_nxt = lru_pkg::S_AGE;
        end
      end

      lru_pkg::S_AGE: begin
        mem_ctl.rd_en = !last;
        if (cnt_r != '0) begin
          if (chk_idx == slot) begin
            mem_ctl.rank_we = 1'b1;
            mem_wr_rank     = '0;
            if (!hit_found_r) begin
              mem_ctl.page_we   = 1'b1;
              mem_ctl.set_valid = 1'b1;
            end
          end else if (chk_valid && (!hit_found_r || (mem_rd_rank < hit_rank_r))) begin
            mem_ctl.rank_we = 1'b1;
            mem_wr_rank     = mem_rd_rank + IW'(1);
          end
        end
        cnt_nxt = cnt_r + CW'(1);
        if (last) begin
          cnt_nxt   = '0;
          state_nxt = lru_pkg::S_RESULT;
        end
      end

      lru_pkg::S_RESULT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt    = 1'b1;
          out_hit_nxt      = hit_found_r;
          out_frame_nxt    = lru_pkg::FRAME_W'(slot);
          out_ev_valid_nxt = evict;
          out_ev_page_nxt  = evict ? vic_page_r : '0;
          state_nxt        = lru_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = lru_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lru_pkg::S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r          <= key_nxt;
    hit_found_r    <= hit_found_nxt;
    hit_idx_r      <= hit_idx_nxt;
    hit_rank_r     <= hit_rank_nxt;
    empty_found_r  <= empty_found_nxt;
    empty_idx_r    <= empty_idx_nxt;
    vic_idx_r      <= vic_idx_nxt;
    vic_rank_r     <= vic_rank_nxt;
    vic_page_r     <= vic_page_nxt;
    out_hit_r      <= out_hit_nxt;
    out_frame_r    <= out_frame_nxt;
    out_ev_valid_r <= out_ev_valid_nxt;
    out_ev_page_r  <= out_ev_page_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_frame         = out_frame_r;
  assign out_evicted_valid = out_ev_valid_r;
  assign out_evicted_page  = out_ev_page_r;

endmodule

/* rtl/lru_page_replacement_core.sv */
// ----------------------------------------------------------------------------
// lru_page_replacement_core
// Each item runs through a lookup pass and a rank update pass, both through
// the single read port of the frame memories, and then into the result
// register. A new item is taken only once the previous one is done with
// these passes; it is taken while a result still waits.
// Reset: synchronous, active low; clears frame valid flags and handshake
// state, no clearing pass over the memories.
// ----------------------------------------------------------------------------
module lru_page_replacement_core #(
  parameter int unsigned NUM_FRAMES = lru_pkg::DEF_NUM_FRAMES
) (
  input logic       clk,
  input logic       rst_n,
  lru_req_if.sink   in_ch,
  lru_rsp_if.source out_ch
);

  localparam int unsigned IW = $clog2(NUM_FRAMES);

  lru_pkg::lru_mem_ctl_t      mem_ctl;
  logic [IW-1:0]              mem_rd_addr;
  logic [IW-1:0]              mem_wr_addr;
  logic [lru_pkg::PAGE_W-1:0] mem_wr_page;
  logic [IW-1:0]              mem_wr_rank;
  logic [lru_pkg::PAGE_W-1:0] mem_rd_page;
  logic [IW-1:0]              mem_rd_rank;
  logic [NUM_FRAMES-1:0]      frame_valid;

  lru_ctrl #(
    .NUM_FRAMES(NUM_FRAMES)
  ) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_ch.valid),
    .in_ready          (in_ch.ready),
    .in_page_id        (in_ch.page_id),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_hit           (out_ch.hit),
    .out_frame         (out_ch.frame),
    .out_evicted_valid (out_ch.evicted_valid),
    .out_evicted_page  (out_ch.evicted_page),
    .mem_ctl           (mem_ctl),
    .mem_rd_addr       (mem_rd_addr),
    .mem_wr_addr       (mem_wr_addr),
    .mem_wr_page       (mem_wr_page),
    .mem_wr_rank       (mem_wr_rank),
    .mem_rd_page       (mem_rd_page),
    .mem_rd_rank       (mem_rd_rank),
    .frame_valid       (frame_valid)
  );

  lru_frame_store #(
    .NUM_FRAMES(NUM_FRAMES)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mem_ctl),
    .rd_addr (mem_rd_addr),
    .wr_addr (mem_wr_addr),
    .wr_page (mem_wr_page),
    .wr_rank (mem_wr_rank),
    .rd_page (mem_rd_page),
    .rd_rank (mem_rd_rank),
    .valid   (frame_valid)
  );

endmodule

/* rtl/lru_checker.sv */
// ----------------------------------------------------------------------------
// lru_checker
// Port level checks for the lru page replacement core, bound to the top level.
// ----------------------------------------------------------------------------
module lru_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_hit,
  input logic [lru_pkg::FRAME_W-1:0] out_frame,
  input logic                        out_evicted_valid,
  input logic [lru_pkg::PAGE_W-1:0]  out_evicted_page
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hit) && $stable(out_frame)
      && $stable(out_evicted_valid) && $stable(out_evicted_page))
    else $error("result changed while stalled");

  // one item at a time
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item taken while previous access in flight");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_hit && out_evicted_valid))
    else $error("eviction reported on a hit");

  a_evict_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_evicted_valid |-> out_evicted_page == '0)
    else $error("evicted page not zero without eviction");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("not idle right after reset");

endmodule

bind lru_page_replacement_core lru_checker u_lru_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_hit           (out_ch.hit),
  .out_frame         (out_ch.frame),
  .out_evicted_valid (out_ch.evicted_valid),
  .out_evicted_page  (out_ch.evicted_page)
);
